[rtl/fplt_pkg.sv]
// Shared types and constants for the file page list table.
// No dependencies; imported by the sequencer, the top level and the bench.
package fplt_pkg;

    localparam int HEAD_W = 8;
    localparam int PAGE_W = 20;
    localparam int ADDR_W = 56;

    // Request codes carried on the mode field
    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_FIND   = 2'd2;
    localparam logic [1:0] MODE_REMOVE = 2'd3;

    typedef struct packed {
        logic [HEAD_W-1:0] node_index;
        logic [ADDR_W-1:0] found_address;
        logic              hit;
        logic              status;
    } fplt_result_t;

endpackage

[rtl/fplt_ram.sv]
// Node memory: one write port, one read port, registered read data.
// No dependencies.
module fplt_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 86
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/fplt_seq.sv]
// Request sequencer: clearing pass, free list, list walks and node updates.
// Depends on fplt_pkg; drives the node memory in fplt_ram.
module fplt_seq #(
    parameter int NODES     = 256,
    parameter int PAGE_BITS = 20,
    parameter int IW        = $clog2(NODES),
    parameter int DW        = IW + 1 + PAGE_BITS + 1 + fplt_pkg::ADDR_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [fplt_pkg::HEAD_W-1:0]   s_list_head,
    input  logic [fplt_pkg::PAGE_W-1:0]   s_page_number,
    input  logic [fplt_pkg::ADDR_W-1:0]   s_page_address,
    output fplt_pkg::fplt_result_t        res,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          mem_we,
    output logic [IW-1:0]                 mem_waddr,
    output logic [DW-1:0]                 mem_wdata,
    output logic                          mem_re,
    output logic [IW-1:0]                 mem_raddr,
    input  logic [DW-1:0]                 mem_rdata
);
    import fplt_pkg::*;

    localparam int LW = IW + 1;             // link: none flag on top of the index
    localparam int TW = PAGE_BITS + 1;      // tag: empty marker on top of the page
    localparam int CW = $clog2(NODES + 1);  // walk step count up to NODES

    localparam logic [LW-1:0] LINK_NONE = {1'b1, {IW{1'b0}}};
    localparam logic [TW-1:0] EMPTY_TAG = {1'b1, {PAGE_BITS{1'b0}}};
    localparam logic [IW-1:0] LAST_IDX  = IW'(NODES - 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_C_RD, ST_A_FREE, ST_A_HEAD, ST_A_NODE,
        ST_F_RD, ST_R_I, ST_R_N, ST_R_WR, ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   clr_reg, clr_next;
    logic [LW-1:0]   free_reg, free_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [PAGE_BITS-1:0] pg_reg, pg_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LW-1:0]   n_reg, n_next;
    logic [IW-1:0]   i_reg, i_next;
    logic [DW-1:0]   wi_reg, wi_next;
    logic [CW-1:0]   steps_reg, steps_next;
    fplt_result_t    res_reg, res_next;

    logic [31:0]     head_wide, pg_wide, n_wide;
    logic [IW-1:0]   head_idx;
    logic            head_ok;
    logic [PAGE_BITS-1:0] pg_in;
    logic [LW-1:0]   rd_link, wi_link;
    logic [TW-1:0]   rd_tag, wi_tag;
    logic [ADDR_W-1:0] rd_addr, wi_addr;
    logic            rd_match;
    logic [CW-1:0]   steps_inc;
    logic            steps_last;

    assign head_wide = 32'(s_list_head);
    assign head_idx  = head_wide[IW-1:0];
    assign head_ok   = head_wide < 32'(NODES);
    assign pg_wide   = 32'(s_page_number);
    assign pg_in     = pg_wide[PAGE_BITS-1:0];
    assign n_wide    = 32'(n_reg[IW-1:0]);

    assign rd_link  = mem_rdata[DW-1 -: LW];
    assign rd_tag   = mem_rdata[ADDR_W +: TW];
    assign rd_addr  = mem_rdata[ADDR_W-1:0];
    assign wi_link  = wi_reg[DW-1 -: LW];
    assign wi_tag   = wi_reg[ADDR_W +: TW];
    assign wi_addr  = wi_reg[ADDR_W-1:0];
    assign rd_match = rd_tag == {1'b0, pg_reg};

    assign steps_inc  = steps_reg + 1'b1;
    assign steps_last = steps_inc == CW'(NODES);

    assign s_ready   = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign res       = res_reg;

    // No state issues a read in the cycle it writes, and every walk re-reads
    // after the last write of the previous transaction, so no forwarding.
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        free_next  = free_reg;
        head_next  = head_reg;
        pg_next    = pg_reg;
        addr_next  = addr_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        wi_next    = wi_reg;
        steps_next = steps_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {(clr_reg == LAST_IDX) ? LINK_NONE : {1'b0, clr_reg + 1'b1},
                             EMPTY_TAG, {ADDR_W{1'b0}}};
                if (clr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    pg_next    = pg_in;
                    addr_next  = s_page_address;
                    head_next  = head_idx;
                    i_next     = head_idx;
                    n_next     = free_reg;
                    steps_next = '0;
                    res_next   = '0;
                    state_next = ST_DONE;
                    case (s_mode)
                        MODE_CREATE: begin
                            if (free_reg[IW]) begin
                                res_next.status = 1'b1;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = free_reg[IW-1:0];
                                state_next = ST_C_RD;
                            end
                        end
                        MODE_ADD: begin
                            if (head_ok) begin
                                if (free_reg[IW]) begin
                                    res_next.status = 1'b1;
                                end else begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = free_reg[IW-1:0];
                                    state_next = ST_A_FREE;
                                end
                            end
                        end
                        MODE_FIND: begin
                            if (head_ok) begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_idx;
                                state_next = ST_F_RD;
                            end
                        end
                        MODE_REMOVE: begin
                            if (head_ok) begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_idx;
                                state_next = ST_R_I;
                            end
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_C_RD: begin
                free_next  = rd_link;
                mem_we     = 1'b1;
                mem_waddr  = n_reg[IW-1:0];
                mem_wdata  = {LINK_NONE, EMPTY_TAG, {ADDR_W{1'b0}}};
                res_next.node_index = n_wide[HEAD_W-1:0];
                state_next = ST_DONE;
            end
            ST_A_FREE: begin
                free_next  = rd_link;
                mem_re     = 1'b1;
                mem_raddr  = head_reg;
                state_next = ST_A_HEAD;
            end
            ST_A_HEAD: begin
                wi_next    = mem_rdata;
                mem_we     = 1'b1;
                mem_waddr  = head_reg;
                mem_wdata  = {n_reg, rd_tag, rd_addr};
                state_next = ST_A_NODE;
            end
            ST_A_NODE: begin
                // head taken from the free list itself ends up linking to itself
                mem_we     = 1'b1;
                mem_waddr  = n_reg[IW-1:0];
                mem_wdata  = {(head_reg == n_reg[IW-1:0]) ? n_reg : wi_link,
                              {1'b0, pg_reg}, addr_reg};
                state_next = ST_DONE;
            end
            ST_F_RD: begin
                if (rd_match) begin
                    res_next.hit           = 1'b1;
                    res_next.found_address = rd_addr;
                    state_next             = ST_DONE;
                end else if (rd_link[IW] || steps_last) begin
                    state_next = ST_DONE;
                end else begin
                    steps_next = steps_inc;
                    mem_re     = 1'b1;
                    mem_raddr  = rd_link[IW-1:0];
                end
            end
            ST_R_I: begin
                wi_next = mem_rdata;
                if (rd_link[IW]) begin
                    state_next = ST_DONE;
                end else begin
                    n_next     = rd_link;
                    mem_re     = 1'b1;
                    mem_raddr  = rd_link[IW-1:0];
                    state_next = ST_R_N;
                end
            end
            ST_R_N: begin
                if (rd_match) begin
                    // unlink: predecessor takes the successor of the match
                    mem_we     = 1'b1;
                    mem_waddr  = i_reg;
                    mem_wdata  = {rd_link, wi_tag, wi_addr};
                    state_next = ST_R_WR;
                end else if (steps_last) begin
                    state_next = ST_DONE;
                end else begin
                    steps_next = steps_inc;
                    wi_next    = mem_rdata;
                    i_next     = n_reg[IW-1:0];
                    if (rd_link[IW]) begin
                        state_next = ST_DONE;
                    end else begin
                        n_next    = rd_link;
                        mem_re    = 1'b1;
                        mem_raddr = rd_link[IW-1:0];
                    end
                end
            end
            ST_R_WR: begin
                mem_we       = 1'b1;
                mem_waddr    = n_reg[IW-1:0];
                mem_wdata    = {free_reg, EMPTY_TAG, {ADDR_W{1'b0}}};
                free_next    = n_reg;
                res_next.hit = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            free_reg  <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg  <= head_next;
        pg_reg    <= pg_next;
        addr_reg  <= addr_next;
        n_reg     <= n_next;
        i_reg     <= i_next;
        wi_reg    <= wi_next;
        steps_reg <= steps_next;
        res_reg   <= res_next;
    end

endmodule

[rtl/file_page_list_table.sv]
// Top level of the file page list table: sequencer, node memory, output register.
// Depends on fplt_pkg, fplt_ram and fplt_seq.
//
// One request per transaction, one result per request. After reset the block
// runs a clearing pass over the node memory with s_ready low. Each request
// costs one memory read per node it touches, plus a hand-over to the output
// register. A find walk reads at most NODES nodes and a remove walk at most
// NODES+1 (the head is read first). The walk through the single read port of
// the node memory sets the rate; requests are taken one at a time, while a
// finished result may still wait in the output register.
module file_page_list_table #(
    parameter int NODES     = 256,
    parameter int PAGE_BITS = 20
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [fplt_pkg::HEAD_W-1:0] s_list_head,
    input  logic [fplt_pkg::PAGE_W-1:0] s_page_number,
    input  logic [fplt_pkg::ADDR_W-1:0] s_page_address,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fplt_pkg::HEAD_W-1:0] m_node_index,
    output logic [fplt_pkg::ADDR_W-1:0] m_found_address,
    output logic                        m_hit,
    output logic                        m_status
);
    import fplt_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int DW = IW + 1 + PAGE_BITS + 1 + ADDR_W;

    fplt_result_t  res;
    logic          res_valid, res_ready;
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata, mem_rdata;

    logic          m_valid_reg, m_valid_next;
    fplt_result_t  m_res_reg, m_res_next;

    fplt_seq #(
        .NODES(NODES), .PAGE_BITS(PAGE_BITS), .IW(IW), .DW(DW)
    ) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_list_head(s_list_head), .s_page_number(s_page_number),
        .s_page_address(s_page_address),
        .res(res), .res_valid(res_valid), .res_ready(res_ready),
        .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
        .mem_re(mem_re), .mem_raddr(mem_raddr), .mem_rdata(mem_rdata)
    );

    fplt_ram #(
        .DEPTH(NODES), .AW(IW), .DW(DW)
    ) u_ram (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_node_index    = m_res_reg.node_index;
    assign m_found_address = m_res_reg.found_address;
    assign m_hit           = m_res_reg.hit;
    assign m_status        = m_res_reg.status;

endmodule

[rtl/fplt_checker.sv]
// Port-level checks for the file page list table, bound to the top level.
// Depends only on the top level's ports.
module fplt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_node_index,
    input logic [55:0] m_found_address,
    input logic        m_hit,
    input logic        m_status
);

    default disable iff (!aresetn);

    // stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge aclk)
        m_valid && !m_ready |=> m_valid && $stable(m_found_address) &&
        $stable(m_node_index) && $stable(m_hit) && $stable(m_status))
        else $error("result changed while stalled");

    // one request at a time: busy right after a transaction is taken
    a_busy_after_accept: assert property (@(posedge aclk)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again straight after a transaction");

    a_status_clean: assert property (@(posedge aclk)
        m_valid && m_status |-> !m_hit && m_found_address == 56'd0 &&
        m_node_index == 8'd0)
        else $error("out-of-nodes result carries other fields");

    a_miss_no_addr: assert property (@(posedge aclk)
        m_valid && !m_hit |-> m_found_address == 56'd0)
        else $error("address returned without a hit");

    a_create_only: assert property (@(posedge aclk)
        m_valid && m_node_index != 8'd0 |-> !m_hit && !m_status)
        else $error("node index on a non-create result");

endmodule

bind file_page_list_table fplt_checker u_fplt_checker (.*);

[bench/file_page_list_table_test.sv]
// Self-checking bench for file_page_list_table: directed and random list requests,
// a shadow node pool predicts each result. Depends on fplt_pkg and the RTL top level.
module file_page_list_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fplt_pkg::*;

    localparam int NODE_COUNT = 256;
    localparam int PAGE_WIDTH = 20;
    localparam logic [8:0]  NO_LINK    = 9'(NODE_COUNT);
    localparam logic [20:0] EMPTY_MARK = 21'(1 << PAGE_WIDTH);
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 200;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_mode = MODE_CREATE;
    logic [HEAD_W-1:0]   s_list_head = '0;
    logic [PAGE_W-1:0]   s_page_number = '0;
    logic [ADDR_W-1:0]   s_page_address = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [HEAD_W-1:0]   m_node_index;
    logic [ADDR_W-1:0]   m_found_address;
    logic                m_hit;
    logic                m_status;

    file_page_list_table #(
        .NODES     (NODE_COUNT),
        .PAGE_BITS (PAGE_WIDTH)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_list_head     (s_list_head),
        .s_page_number   (s_page_number),
        .s_page_address  (s_page_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_node_index    (m_node_index),
        .m_found_address (m_found_address),
        .m_hit           (m_hit),
        .m_status        (m_status)
    );

    always #4 aclk = ~aclk;

    // shadow copy of the node pool
    logic [8:0]        link_mem [NODE_COUNT];
    logic [20:0]       tag_mem  [NODE_COUNT];
    logic [ADDR_W-1:0] addr_mem [NODE_COUNT];
    logic [8:0]        free_ptr;

    fplt_result_t pending_results[$];
    logic [7:0]   file_heads[$];
    logic [19:0]  page_pool[12];
    int           errors = 0;
    int           quiet_cycles = 0;
    int           hold_request = 0;
    bit           sender_gaps = 1'b1;
    bit           receiver_stalls = 1'b1;
    bit           offering = 1'b0;

    function automatic logic [8:0] clamp_link(input logic [8:0] v);
        return (v < NODE_COUNT) ? v : NO_LINK;
    endfunction

    function automatic logic [8:0] take_free_node();
        logic [8:0] n;
        n = free_ptr;
        if (n >= NODE_COUNT)
            return NO_LINK;
        free_ptr = clamp_link(link_mem[n[7:0]]);
        return n;
    endfunction

    task automatic clear_pool_model();
        for (int i = 0; i < NODE_COUNT; i++) begin
            link_mem[i] = clamp_link(9'(i + 1));
            tag_mem[i]  = EMPTY_MARK;
            addr_mem[i] = '0;
        end
        free_ptr = '0;
    endtask

    // Applies one request to the shadow pool and returns the answer it must give.
    function automatic fplt_result_t apply_request(input logic [1:0] mode,
            input logic [7:0] head, input logic [19:0] page, input logic [ADDR_W-1:0] addr);
        fplt_result_t r;
        logic [8:0]   n;
        logic [8:0]   cur;
        logic [20:0]  key;
        int           steps;
        bit           done;
        r = '0;
        key = {1'b0, page};
        cur = {1'b0, head};
        steps = 0;
        done = 1'b0;
        case (mode)
            MODE_CREATE: begin
                n = take_free_node();
                if (n == NO_LINK) begin
                    r.status = 1'b1;
                end else begin
                    link_mem[n[7:0]] = NO_LINK;
                    tag_mem[n[7:0]]  = EMPTY_MARK;
                    addr_mem[n[7:0]] = '0;
                    r.node_index = n[7:0];
                end
            end
            MODE_ADD: begin
                n = take_free_node();
                if (n == NO_LINK) begin
                    r.status = 1'b1;
                end else begin
                    link_mem[n[7:0]] = clamp_link(link_mem[head]);
                    link_mem[head]   = n;
                    tag_mem[n[7:0]]  = key;
                    addr_mem[n[7:0]] = addr;
                end
            end
            MODE_FIND: begin
                // the head is compared too; its empty marker never matches
                while (!done && steps < NODE_COUNT && cur < NODE_COUNT) begin
                    if (tag_mem[cur[7:0]] == key) begin
                        r.found_address = addr_mem[cur[7:0]];
                        r.hit = 1'b1;
                        done = 1'b1;
                    end else begin
                        cur = link_mem[cur[7:0]];
                    end
                    steps++;
                end
            end
            MODE_REMOVE: begin
                while (!done && steps < NODE_COUNT && cur < NODE_COUNT) begin
                    n = link_mem[cur[7:0]];
                    if (n >= NODE_COUNT) begin
                        done = 1'b1;
                    end else if (tag_mem[n[7:0]] == key) begin
                        link_mem[cur[7:0]] = clamp_link(link_mem[n[7:0]]);
                        link_mem[n[7:0]]   = free_ptr;
                        free_ptr           = n;
                        tag_mem[n[7:0]]    = EMPTY_MARK;
                        addr_mem[n[7:0]]   = '0;
                        r.hit = 1'b1;
                        done = 1'b1;
                    end else begin
                        cur = n;
                    end
                    steps++;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
            input logic [63:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        errors++;
    endtask

    // One request transaction; the expected answer is worked out when it is taken.
    task automatic send_request(input logic [1:0] mode, input logic [7:0] head,
            input logic [19:0] page, input logic [ADDR_W-1:0] addr,
            output fplt_result_t predicted);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            if (offering)
                s_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_list_head    <= head;
        s_page_number  <= page;
        s_page_address <= addr;
        offering = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(mode, head, page, addr);
        pending_results.push_back(predicted);
    endtask

    task automatic stop_offering();
        if (offering)
            s_valid <= 1'b0;
        offering = 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_head(input int stray_pct);
        if (file_heads.size() == 0 || $urandom_range(0, 99) < stray_pct)
            return 8'($urandom_range(0, 255));
        return file_heads[$urandom_range(0, file_heads.size() - 1)];
    endfunction

    function automatic logic [19:0] pick_page();
        if ($urandom_range(0, 99) < 85)
            return page_pool[$urandom_range(0, 11)];
        return 20'($urandom);
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    task automatic choose_idling();
        sender_gaps     = $urandom_range(0, 3) != 0;
        receiver_stalls = $urandom_range(0, 3) != 0;
    endtask

    task automatic test_directed();
        fplt_result_t res;
        logic [7:0]   h0, h1;
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        send_request(MODE_CREATE, 8'd0, 20'd0, '0, res);
        h0 = res.node_index;
        send_request(MODE_CREATE, 8'hFF, 20'hFFFFF, '1, res);
        h1 = res.node_index;
        file_heads.push_back(h0);
        file_heads.push_back(h1);
        send_request(MODE_ADD, h0, 20'd0, '1, res);
        send_request(MODE_ADD, h0, 20'hFFFFF, '0, res);
        // duplicate page: newest entry sits first
        send_request(MODE_ADD, h0, 20'd0, 56'h01_2345_6789_ABCD, res);
        send_request(MODE_FIND, h0, 20'd0, '0, res);
        send_request(MODE_FIND, h0, 20'hFFFFF, '0, res);
        send_request(MODE_FIND, h0, 20'h55555, '0, res);
        send_request(MODE_FIND, h1, 20'd0, '0, res);
        send_request(MODE_REMOVE, h0, 20'd0, '0, res);
        send_request(MODE_FIND, h0, 20'd0, '0, res);
        send_request(MODE_REMOVE, h0, 20'h55555, '0, res);
        send_request(MODE_REMOVE, h1, 20'd0, '0, res);
        send_request(MODE_ADD, h1, 20'hAAAAA, 56'hAA_AAAA_AAAA_AAAA, res);
        send_request(MODE_FIND, h1, 20'hAAAAA, '0, res);
        // the node freed above is already back in use; this add takes a fresh node
        send_request(MODE_ADD, h0, 20'd7, 56'h55_5555_5555_5555, res);
        send_request(MODE_FIND, h0, 20'd7, '0, res);
        send_request(MODE_REMOVE, h1, 20'hAAAAA, '0, res);
        send_request(MODE_FIND, h1, 20'hAAAAA, '0, res);
        stop_offering();
        wait_for_results();
    endtask

    // Receiver holds off while requests keep coming, so the block must stall its input.
    task automatic test_backpressure();
        fplt_result_t res;
        logic [1:0]   mode;
        sender_gaps = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 24; k++) begin
            mode = ($urandom_range(0, 1) != 0) ? MODE_ADD : MODE_FIND;
            send_request(mode, pick_head(0), pick_page(), random_address(), res);
        end
        stop_offering();
        wait_for_results();
    endtask

    task automatic test_random_mix(input int count);
        fplt_result_t res;
        logic [1:0]   mode;
        int           pick;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0)
                choose_idling();
            pick = $urandom_range(0, 99);
            if (pick < 10)
                mode = MODE_CREATE;
            else if (pick < 45)
                mode = MODE_ADD;
            else if (pick < 75)
                mode = MODE_FIND;
            else
                mode = MODE_REMOVE;
            send_request(mode, pick_head(8), pick_page(), random_address(), res);
            if (mode == MODE_CREATE && !res.status)
                file_heads.push_back(res.node_index);
        end
        stop_offering();
        wait_for_results();
    endtask

    // Fill the pool until adds fail, then check create fails and recovery after removes.
    task automatic test_pool_exhaustion();
        fplt_result_t res;
        int           fails;
        fails = 0;
        for (int k = 0; k < 300 && fails < 3; k++) begin
            if (k % 40 == 0)
                choose_idling();
            send_request(MODE_ADD, pick_head(0), pick_page(), random_address(), res);
            if (res.status)
                fails++;
        end
        send_request(MODE_CREATE, 8'($urandom), 20'($urandom), random_address(), res);
        for (int k = 0; k < 12; k++)
            send_request(MODE_REMOVE, pick_head(0), pick_page(), random_address(), res);
        send_request(MODE_CREATE, 8'($urandom), 20'($urandom), random_address(), res);
        if (!res.status)
            file_heads.push_back(res.node_index);
        stop_offering();
        wait_for_results();
    endtask

    // result side: random stalls plus a long hold-off on request
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request > 0) begin
                m_ready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end
            stall = receiver_stalls ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        fplt_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", 64'(m_node_index), '0);
            end else begin
                want = pending_results.pop_front();
                if (m_node_index !== want.node_index)
                    report_mismatch("node_index", 64'(m_node_index), 64'(want.node_index));
                if (m_found_address !== want.found_address)
                    report_mismatch("found_address", 64'(m_found_address),
                                    64'(want.found_address));
                if (m_hit !== want.hit)
                    report_mismatch("hit", 64'(m_hit), 64'(want.hit));
                if (m_status !== want.status)
                    report_mismatch("status", 64'(m_status), 64'(want.status));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        clear_pool_model();
        page_pool[0] = 20'd0;
        page_pool[1] = 20'hFFFFF;
        for (int i = 2; i < 12; i++)
            page_pool[i] = 20'($urandom);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_mix(200);
        test_pool_exhaustion();
        test_random_mix(40);

        // walks can run NODES+1 reads, so leave room for a late result
        repeat (NODE_COUNT + 8) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 64'(pending_results.size()), '0);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/fplt_pkg.sv
rtl/fplt_ram.sv
rtl/fplt_seq.sv
rtl/file_page_list_table.sv
rtl/fplt_checker.sv
bench/file_page_list_table_test.sv
